>>> src/eacvt_pkg.sv
package eacvt_pkg;

  // Conversion select codes
  typedef enum logic [1:0] {
    CONV_NONE = 2'd0,
    CONV_E2A  = 2'd1,
    CONV_A2E  = 2'd2,
    CONV_A2I  = 2'd3
  } conv_t;

  // Configuration register indexes
  localparam logic [1:0] REG_CONVERSION    = 2'd0;
  localparam logic [1:0] REG_UPPER_CASE    = 2'd1;
  localparam logic [1:0] REG_LOWER_CASE    = 2'd2;
  localparam logic [1:0] REG_RECORD_LENGTH = 2'd3;

  // Longest record that blocking honors
  localparam logic [14:0] MAX_RECORD = 15'd32766;

  // Character constants
  localparam logic [7:0] CH_NEWLINE     = 8'o012;
  localparam logic [7:0] CH_SPACE       = 8'o040;
  localparam logic [7:0] CH_BLANK_EBCD  = 8'o100;

  // Per-stream state word, kept in the state RAM
  typedef struct packed {
    logic [15:0] column;
    logic [14:0] pending_spaces;
    logic [15:0] truncations;
  } state_t;

  localparam int STATE_W = $bits(state_t);

  // Fold a..z up, then A..Z down
  function automatic logic [7:0] fold_case(input logic [7:0] b, input logic up,
                                           input logic lo);
    logic [7:0] r;
    r = b;
    if (up && (r inside {[8'h61:8'h7A]})) r = r - 8'h20;
    if (lo && (r inside {[8'h41:8'h5A]})) r = r + 8'h20;
    return r;
  endfunction

  localparam logic [7:0] EBC_TO_ASC [256] = '{
    8'o000, 8'o001, 8'o002, 8'o003, 8'o234, 8'o011, 8'o206, 8'o177,
    8'o227, 8'o215, 8'o216, 8'o013, 8'o014, 8'o015, 8'o016, 8'o017,
    8'o020, 8'o021, 8'o022, 8'o023, 8'o235, 8'o205, 8'o010, 8'o207,
    8'o030, 8'o031, 8'o222, 8'o217, 8'o034, 8'o035, 8'o036, 8'o037,
    8'o200, 8'o201, 8'o202, 8'o203, 8'o204, 8'o012, 8'o027, 8'o033,
    8'o210, 8'o211, 8'o212, 8'o213, 8'o214, 8'o005, 8'o006, 8'o007,
    8'o220, 8'o221, 8'o026, 8'o223, 8'o224, 8'o225, 8'o226, 8'o004,
    8'o230, 8'o231, 8'o232, 8'o233, 8'o024, 8'o025, 8'o236, 8'o032,
    8'o040, 8'o240, 8'o241, 8'o242, 8'o243, 8'o244, 8'o245, 8'o246,
    8'o247, 8'o250, 8'o133, 8'o056, 8'o074, 8'o050, 8'o053, 8'o041,
    8'o046, 8'o251, 8'o252, 8'o253, 8'o254, 8'o255, 8'o256, 8'o257,
    8'o260, 8'o261, 8'o135, 8'o044, 8'o052, 8'o051, 8'o073, 8'o136,
    8'o055, 8'o057, 8'o262, 8'o263, 8'o264, 8'o265, 8'o266, 8'o267,
    8'o270, 8'o271, 8'o174, 8'o054, 8'o045, 8'o137, 8'o076, 8'o077,
    8'o272, 8'o273, 8'o274, 8'o275, 8'o276, 8'o277, 8'o300, 8'o301,
    8'o302, 8'o140, 8'o072, 8'o043, 8'o100, 8'o047, 8'o075, 8'o042,
    8'o303, 8'o141, 8'o142, 8'o143, 8'o144, 8'o145, 8'o146, 8'o147,
    8'o150, 8'o151, 8'o304, 8'o305, 8'o306, 8'o307, 8'o310, 8'o311,
    8'o312, 8'o152, 8'o153, 8'o154, 8'o155, 8'o156, 8'o157, 8'o160,
    8'o161, 8'o162, 8'o313, 8'o314, 8'o315, 8'o316, 8'o317, 8'o320,
    8'o321, 8'o176, 8'o163, 8'o164, 8'o165, 8'o166, 8'o167, 8'o170,
    8'o171, 8'o172, 8'o322, 8'o323, 8'o324, 8'o325, 8'o326, 8'o327,
    8'o330, 8'o331, 8'o332, 8'o333, 8'o334, 8'o335, 8'o336, 8'o337,
    8'o340, 8'o341, 8'o342, 8'o343, 8'o344, 8'o345, 8'o346, 8'o347,
    8'o173, 8'o101, 8'o102, 8'o103, 8'o104, 8'o105, 8'o106, 8'o107,
    8'o110, 8'o111, 8'o350, 8'o351, 8'o352, 8'o353, 8'o354, 8'o355,
    8'o175, 8'o112, 8'o113, 8'o114, 8'o115, 8'o116, 8'o117, 8'o120,
    8'o121, 8'o122, 8'o356, 8'o357, 8'o360, 8'o361, 8'o362, 8'o363,
    8'o134, 8'o237, 8'o123, 8'o124, 8'o125, 8'o126, 8'o127, 8'o130,
    8'o131, 8'o132, 8'o364, 8'o365, 8'o366, 8'o367, 8'o370, 8'o371,
    8'o060, 8'o061, 8'o062, 8'o063, 8'o064, 8'o065, 8'o066, 8'o067,
    8'o070, 8'o071, 8'o372, 8'o373, 8'o374, 8'o375, 8'o376, 8'o377
  };

  localparam logic [7:0] ASC_TO_EBC [256] = '{
    8'o000, 8'o001, 8'o002, 8'o003, 8'o067, 8'o055, 8'o056, 8'o057,
    8'o026, 8'o005, 8'o045, 8'o013, 8'o014, 8'o015, 8'o016, 8'o017,
    8'o020, 8'o021, 8'o022, 8'o023, 8'o074, 8'o075, 8'o062, 8'o046,
    8'o030, 8'o031, 8'o077, 8'o047, 8'o034, 8'o035, 8'o036, 8'o037,
    8'o100, 8'o117, 8'o177, 8'o173, 8'o133, 8'o154, 8'o120, 8'o175,
    8'o115, 8'o135, 8'o134, 8'o116, 8'o153, 8'o140, 8'o113, 8'o141,
    8'o360, 8'o361, 8'o362, 8'o363, 8'o364, 8'o365, 8'o366, 8'o367,
    8'o370, 8'o371, 8'o172, 8'o136, 8'o114, 8'o176, 8'o156, 8'o157,
    8'o174, 8'o301, 8'o302, 8'o303, 8'o304, 8'o305, 8'o306, 8'o307,
    8'o310, 8'o311, 8'o321, 8'o322, 8'o323, 8'o324, 8'o325, 8'o326,
    8'o327, 8'o330, 8'o331, 8'o342, 8'o343, 8'o344, 8'o345, 8'o346,
    8'o347, 8'o350, 8'o351, 8'o112, 8'o340, 8'o132, 8'o137, 8'o155,
    8'o171, 8'o201, 8'o202, 8'o203, 8'o204, 8'o205, 8'o206, 8'o207,
    8'o210, 8'o211, 8'o221, 8'o222, 8'o223, 8'o224, 8'o225, 8'o226,
    8'o227, 8'o230, 8'o231, 8'o242, 8'o243, 8'o244, 8'o245, 8'o246,
    8'o247, 8'o250, 8'o251, 8'o300, 8'o152, 8'o320, 8'o241, 8'o007,
    8'o040, 8'o041, 8'o042, 8'o043, 8'o044, 8'o025, 8'o006, 8'o027,
    8'o050, 8'o051, 8'o052, 8'o053, 8'o054, 8'o011, 8'o012, 8'o033,
    8'o060, 8'o061, 8'o032, 8'o063, 8'o064, 8'o065, 8'o066, 8'o010,
    8'o070, 8'o071, 8'o072, 8'o073, 8'o004, 8'o024, 8'o076, 8'o341,
    8'o101, 8'o102, 8'o103, 8'o104, 8'o105, 8'o106, 8'o107, 8'o110,
    8'o111, 8'o121, 8'o122, 8'o123, 8'o124, 8'o125, 8'o126, 8'o127,
    8'o130, 8'o131, 8'o142, 8'o143, 8'o144, 8'o145, 8'o146, 8'o147,
    8'o150, 8'o151, 8'o160, 8'o161, 8'o162, 8'o163, 8'o164, 8'o165,
    8'o166, 8'o167, 8'o170, 8'o200, 8'o212, 8'o213, 8'o214, 8'o215,
    8'o216, 8'o217, 8'o220, 8'o232, 8'o233, 8'o234, 8'o235, 8'o236,
    8'o237, 8'o240, 8'o252, 8'o253, 8'o254, 8'o255, 8'o256, 8'o257,
    8'o260, 8'o261, 8'o262, 8'o263, 8'o264, 8'o265, 8'o266, 8'o267,
    8'o270, 8'o271, 8'o272, 8'o273, 8'o274, 8'o275, 8'o276, 8'o277,
    8'o312, 8'o313, 8'o314, 8'o315, 8'o316, 8'o317, 8'o332, 8'o333,
    8'o334, 8'o335, 8'o336, 8'o337, 8'o352, 8'o353, 8'o354, 8'o355,
    8'o356, 8'o357, 8'o372, 8'o373, 8'o374, 8'o375, 8'o376, 8'o377
  };

  localparam logic [7:0] ASC_TO_IBM [256] = '{
    8'o000, 8'o001, 8'o002, 8'o003, 8'o067, 8'o055, 8'o056, 8'o057,
    8'o026, 8'o005, 8'o045, 8'o013, 8'o014, 8'o015, 8'o016, 8'o017,
    8'o020, 8'o021, 8'o022, 8'o023, 8'o074, 8'o075, 8'o062, 8'o046,
    8'o030, 8'o031, 8'o077, 8'o047, 8'o034, 8'o035, 8'o036, 8'o037,
    8'o100, 8'o132, 8'o177, 8'o173, 8'o133, 8'o154, 8'o120, 8'o175,
    8'o115, 8'o135, 8'o134, 8'o116, 8'o153, 8'o140, 8'o113, 8'o141,
    8'o360, 8'o361, 8'o362, 8'o363, 8'o364, 8'o365, 8'o366, 8'o367,
    8'o370, 8'o371, 8'o172, 8'o136, 8'o114, 8'o176, 8'o156, 8'o157,
    8'o174, 8'o301, 8'o302, 8'o303, 8'o304, 8'o305, 8'o306, 8'o307,
    8'o310, 8'o311, 8'o321, 8'o322, 8'o323, 8'o324, 8'o325, 8'o326,
    8'o327, 8'o330, 8'o331, 8'o342, 8'o343, 8'o344, 8'o345, 8'o346,
    8'o347, 8'o350, 8'o351, 8'o255, 8'o340, 8'o275, 8'o137, 8'o155,
    8'o171, 8'o201, 8'o202, 8'o203, 8'o204, 8'o205, 8'o206, 8'o207,
    8'o210, 8'o211, 8'o221, 8'o222, 8'o223, 8'o224, 8'o225, 8'o226,
    8'o227, 8'o230, 8'o231, 8'o242, 8'o243, 8'o244, 8'o245, 8'o246,
    8'o247, 8'o250, 8'o251, 8'o300, 8'o117, 8'o320, 8'o241, 8'o007,
    8'o040, 8'o041, 8'o042, 8'o043, 8'o044, 8'o025, 8'o006, 8'o027,
    8'o050, 8'o051, 8'o052, 8'o053, 8'o054, 8'o011, 8'o012, 8'o033,
    8'o060, 8'o061, 8'o032, 8'o063, 8'o064, 8'o065, 8'o066, 8'o010,
    8'o070, 8'o071, 8'o072, 8'o073, 8'o004, 8'o024, 8'o076, 8'o341,
    8'o101, 8'o102, 8'o103, 8'o104, 8'o105, 8'o106, 8'o107, 8'o110,
    8'o111, 8'o121, 8'o122, 8'o123, 8'o124, 8'o125, 8'o126, 8'o127,
    8'o130, 8'o131, 8'o142, 8'o143, 8'o144, 8'o145, 8'o146, 8'o147,
    8'o150, 8'o151, 8'o160, 8'o161, 8'o162, 8'o163, 8'o164, 8'o165,
    8'o166, 8'o167, 8'o170, 8'o200, 8'o212, 8'o213, 8'o214, 8'o215,
    8'o216, 8'o217, 8'o220, 8'o232, 8'o233, 8'o234, 8'o235, 8'o236,
    8'o237, 8'o240, 8'o252, 8'o253, 8'o254, 8'o255, 8'o256, 8'o257,
    8'o260, 8'o261, 8'o262, 8'o263, 8'o264, 8'o265, 8'o266, 8'o267,
    8'o270, 8'o271, 8'o272, 8'o273, 8'o274, 8'o275, 8'o276, 8'o277,
    8'o312, 8'o313, 8'o314, 8'o315, 8'o316, 8'o317, 8'o332, 8'o333,
    8'o334, 8'o335, 8'o336, 8'o337, 8'o352, 8'o353, 8'o354, 8'o355,
    8'o356, 8'o357, 8'o372, 8'o373, 8'o374, 8'o375, 8'o376, 8'o377
  };

endpackage

>>> src/eacvt_in_if.sv
interface eacvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

>>> src/eacvt_out_if.sv
interface eacvt_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [14:0] repeat_res;
  logic [15:0] truncated_total;
  logic        last;

  modport source (output valid, output out_byte, output repeat_res,
                  output truncated_total, output last, input ready);
  modport sink   (input valid, input out_byte, input repeat_res,
                  input truncated_total, input last, output ready);
endinterface

>>> src/eacvt_cfg_if.sv
interface eacvt_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [14:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/eacvt_ram.sv
module eacvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, returns the old word on a same-cycle write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/ebcdic_ascii_record_converter_unit.sv
// EBCDIC/ASCII byte converter with fixed-record blocking and unblocking.
// Bytes arrive on raw, results leave on res, registers are written on cfg
// (only while the block is idle; the user must ensure this, the block does
// not enforce it). Plain streams (zero or one result per byte) run at one
// byte per clock while res is ready; a byte with k results (up to three,
// e.g. held spaces, a letter and a record newline) holds the input until
// the single output register drains them, one result per cycle while res
// is ready. The stream state (column, held spaces, truncation count) lives
// in a one-word RAM: read when a byte is taken in, updated when it retires,
// forwarded if the next read meets that write. No clearing pass is needed.
module ebcdic_ascii_record_converter_unit (
  input logic clk,
  input logic rst,
  eacvt_in_if.sink    raw,
  eacvt_out_if.source res,
  eacvt_cfg_if.sink   cfg
);
  import eacvt_pkg::*;

  // Configuration registers
  conv_t       conversion;
  logic        upper_case;
  logic        lower_case;
  logic [14:0] record_length;

  // Stage 1: byte under conversion
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_fwd;
  logic [1:0]  idx;
  state_t      last_wr;
  logic        mem_valid;

  // Output register
  logic        o_valid;
  logic [7:0]  o_byte;
  logic [14:0] o_rep;
  logic [15:0] o_trunc;
  logic        o_last;

  // RAM connections
  logic [STATE_W-1:0] rd_word;
  state_t             cur;
  state_t             nxt;

  // Per-byte results
  logic [7:0]  r_byte [3];
  logic [14:0] r_rep  [3];
  logic [1:0]  n;

  logic        load;
  logic        finish;
  logic        accept;

  // Configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      conversion    <= CONV_NONE;
      upper_case    <= 1'b0;
      lower_case    <= 1'b0;
      record_length <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CONVERSION:    conversion    <= conv_t'(cfg.data[1:0]);
        REG_UPPER_CASE:    upper_case    <= cfg.data[0];
        REG_LOWER_CASE:    lower_case    <= cfg.data[0];
        REG_RECORD_LENGTH: record_length <= cfg.data;
        default: ;
      endcase
    end
  end

  // State RAM
  eacvt_ram #(
    .WIDTH (STATE_W),
    .DEPTH (1)
  ) u_state_ram (
    .clk   (clk),
    .we    (finish),
    .waddr (1'b0),
    .wdata (nxt),
    .re    (accept),
    .raddr (1'b0),
    .rdata (rd_word)
  );

  // Pick the current state: forwarded write, stored word, or reset value
  always_comb begin
    if (s1_fwd) begin
      cur = last_wr;
    end else if (mem_valid) begin
      cur = state_t'(rd_word);
    end else begin
      cur = '0;
    end
  end

  // Convert one byte and update the state
  always_comb begin
    logic [14:0] len;
    logic [7:0]  b;
    logic [15:0] col_a;
    logic [14:0] pend_a;
    logic [15:0] len16;
    logic [15:0] gap;

    len    = (record_length > MAX_RECORD) ? MAX_RECORD : record_length;
    len16  = {1'b0, len};
    b      = '0;
    col_a  = '0;
    pend_a = '0;
    gap    = len16 - cur.column;
    nxt    = cur;
    n      = 2'd0;
    for (int i = 0; i < 3; i++) begin
      r_byte[i] = '0;
      r_rep[i]  = 15'd1;
    end

    case (conversion)
      CONV_NONE: begin
        r_byte[0] = fold_case(s1_byte, upper_case, lower_case);
        n = 2'd1;
      end
      CONV_E2A: begin
        b = EBC_TO_ASC[s1_byte];
        if (len == '0) begin
          r_byte[0] = fold_case(b, upper_case, lower_case);
          n = 2'd1;
        end else begin
          // Hold spaces back; flush them ahead of the next visible byte
          if (b == CH_SPACE) begin
            pend_a = (cur.pending_spaces != 15'h7FFF) ? cur.pending_spaces + 15'd1
                                                      : cur.pending_spaces;
          end else begin
            pend_a = '0;
            if (cur.pending_spaces != '0) begin
              r_byte[n] = CH_SPACE;
              r_rep[n]  = cur.pending_spaces;
              n = n + 2'd1;
            end
            r_byte[n] = fold_case(b, upper_case, lower_case);
            n = n + 2'd1;
          end
          col_a = (cur.column != 16'hFFFF) ? cur.column + 16'd1 : cur.column;
          // End of record: drop held spaces, emit newline
          if (col_a >= len16) begin
            r_byte[n] = CH_NEWLINE;
            n = n + 2'd1;
            nxt.column         = '0;
            nxt.pending_spaces = '0;
          end else begin
            nxt.column         = col_a;
            nxt.pending_spaces = pend_a;
          end
        end
      end
      default: begin
        b = fold_case(s1_byte, upper_case, lower_case);
        b = (conversion == CONV_A2E) ? ASC_TO_EBC[b] : ASC_TO_IBM[b];
        if (len == '0) begin
          r_byte[0] = b;
          n = 2'd1;
        end else if (s1_byte == CH_NEWLINE) begin
          // Pad the rest of the record with blanks
          if (cur.column < len16) begin
            r_byte[0] = CH_BLANK_EBCD;
            r_rep[0]  = gap[14:0];
            n = 2'd1;
          end
          nxt.column = '0;
        end else begin
          // Count an overlong line once, then drop its bytes
          if (cur.column == len16 && cur.truncations != 16'hFFFF) begin
            nxt.truncations = cur.truncations + 16'd1;
          end
          if (cur.column <= len16) begin
            nxt.column = cur.column + 16'd1;
          end
          if (cur.column < len16) begin
            r_byte[0] = b;
            n = 2'd1;
          end
        end
      end
    endcase
  end

  // Handshake control
  assign load   = s1_valid && (n != 2'd0) && (!o_valid || res.ready);
  assign finish = s1_valid && ((n == 2'd0) || (load && idx == n - 2'd1));
  assign accept = raw.valid && raw.ready;
  assign raw.ready = !s1_valid || finish;

  // Advance stage 1 and the forwarding path
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s1_fwd    <= 1'b0;
      idx       <= '0;
      mem_valid <= 1'b0;
      o_valid   <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        s1_fwd   <= finish;
      end else if (finish) begin
        s1_valid <= 1'b0;
      end
      if (finish) begin
        idx       <= '0;
        mem_valid <= 1'b1;
      end else if (load) begin
        idx <= idx + 2'd1;
      end
      if (load) begin
        o_valid <= 1'b1;
      end else if (res.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte <= raw.in_byte;
    end
    if (finish) begin
      last_wr <= nxt;
    end
    if (load) begin
      o_byte  <= r_byte[idx];
      o_rep   <= r_rep[idx];
      o_trunc <= nxt.truncations;
      o_last  <= (idx == n - 2'd1);
    end
  end

  assign res.valid           = o_valid;
  assign res.out_byte        = o_byte;
  assign res.repeat_res      = o_rep;
  assign res.truncated_total = o_trunc;
  assign res.last            = o_last;

endmodule
